### sv/ranc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ranc_pkg
// Shared types and constants of the rational add/normalize/compare core.
// ----------------------------------------------------------------------------
package ranc_pkg;

	localparam int SUM_NUM_W = 33;
	localparam int SUM_DEN_W = 31;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_NORM_A,
		ST_NORM_B,
		ST_CROSS,
		ST_NORM_S,
		ST_DONE
	} ranc_state_t;

	typedef enum logic [1:0] {
		GS_IDLE,
		GS_GCD,
		GS_DIVN,
		GS_DIVD
	} ranc_gstate_t;

endpackage : ranc_pkg
`default_nettype wire

### sv/ranc_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ranc_front
// Accepts input fractions, splits each field into sign and magnitude, flags
// a zero denominator and pushes the classified item into a two-entry queue.
// ----------------------------------------------------------------------------
module ranc_front #(
	parameter int W = 16
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [4*W-1:0]   in_data,
	output logic                  q_valid,
	input  wire logic             q_ready,
	output logic [4*W+4:0]        q_data
);

	// entry: {bad, bd_neg, bd_mag, bn_neg, bn_mag, ad_neg, ad_mag, an_neg, an_mag}
	localparam int EW = 4 * (W + 1) + 1;

	logic [EW-1:0] mem_q [2];
	logic          wptr_q, rptr_q;
	logic [1:0]    cnt_q;
	logic [EW-1:0] entry;
	logic [W:0]    fld [4];
	logic          push, pop;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			if (in_data[i*W+W-1])
				fld[i] = {1'b1, ~in_data[i*W +: W] + W'(1)};
			else
				fld[i] = {1'b0, in_data[i*W +: W]};
		end
		entry = {(fld[1][W-1:0] == '0) || (fld[3][W-1:0] == '0),
			fld[3], fld[2], fld[1], fld[0]};
	end

	// most negative value: ~x+1 gives magnitude 2^(W-1), which still fits in
	// W unsigned bits, so the magnitude field never wraps to zero.

	assign in_ready = (cnt_q != 2'd2);
	assign q_valid  = (cnt_q != 2'd0);
	assign q_data   = mem_q[rptr_q];
	assign push     = in_valid && in_ready;
	assign pop      = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (push) mem_q[wptr_q] <= entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push) wptr_q <= ~wptr_q;
			if (pop)  rptr_q <= ~rptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule : ranc_front
`default_nettype wire

### sv/ranc_gcdiv.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ranc_gcdiv
// Shared reduction unit: binary gcd of two magnitudes, then two restoring
// divisions by the gcd, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ranc_gcdiv #(
	parameter int N = 34
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic [N-1:0] x,
	input  wire logic [N-1:0] y,
	output logic              done,
	output logic [N-1:0]      xq,
	output logic [N-1:0]      yq
);

	localparam int CW = $clog2(N + 1);

	ranc_pkg::ranc_gstate_t st_q, st_d;
	logic [N-1:0]  u_q, v_q, x_q, y_q, g_q, quo_q, rem_q, xr_q;
	logic [CW-1:0] sh_q, bit_q;
	logic [N:0]    trial;
	logic          last_bit;

	assign trial    = {rem_q, quo_q[N-1]} - {1'b0, g_q};
	assign last_bit = (bit_q == CW'(0));

	always_comb begin
		st_d = st_q;
		case (st_q)
			ranc_pkg::GS_IDLE: if (start) st_d = ranc_pkg::GS_GCD;
			ranc_pkg::GS_GCD:  if (v_q == '0 || u_q == '0) st_d = ranc_pkg::GS_DIVN;
			ranc_pkg::GS_DIVN: if (last_bit) st_d = ranc_pkg::GS_DIVD;
			ranc_pkg::GS_DIVD: if (last_bit) st_d = ranc_pkg::GS_IDLE;
			default:           st_d = ranc_pkg::GS_IDLE;
		endcase
	end

	always_comb begin
		done = (st_q == ranc_pkg::GS_DIVD) && last_bit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= ranc_pkg::GS_IDLE;
		else         st_q <= st_d;
	end

	always_ff @(posedge clk) begin
		case (st_q)
			ranc_pkg::GS_IDLE: begin
				u_q <= x; v_q <= y; x_q <= x; y_q <= y; sh_q <= '0;
			end
			ranc_pkg::GS_GCD: begin
				if (v_q == '0 || u_q == '0) begin
					// gcd(0,y)=y; load divider for numerator
					g_q   <= (u_q | v_q) << sh_q;
					quo_q <= x_q;
					rem_q <= '0;
					bit_q <= CW'(N - 1);
				end else if (!u_q[0] && !v_q[0]) begin
					u_q <= u_q >> 1; v_q <= v_q >> 1; sh_q <= sh_q + CW'(1);
				end else if (!u_q[0]) begin
					u_q <= u_q >> 1;
				end else if (!v_q[0]) begin
					v_q <= v_q >> 1;
				end else if (u_q >= v_q) begin
					u_q <= (u_q - v_q) >> 1;
				end else begin
					v_q <= (v_q - u_q) >> 1;
				end
			end
			ranc_pkg::GS_DIVN, ranc_pkg::GS_DIVD: begin
				if (last_bit && st_q == ranc_pkg::GS_DIVN) begin
					// keep the numerator quotient, load the denominator
					xr_q  <= {quo_q[N-2:0], ~trial[N]};
					quo_q <= y_q;
					rem_q <= '0;
					bit_q <= CW'(N - 1);
				end else begin
					if (!trial[N]) begin
						rem_q <= trial[N-1:0];
						quo_q <= {quo_q[N-2:0], 1'b1};
					end else begin
						rem_q <= {rem_q[N-2:0], quo_q[N-1]};
						quo_q <= {quo_q[N-2:0], 1'b0};
					end
					bit_q <= bit_q - CW'(1);
				end
			end
			default: ;
		endcase
	end

	assign xq = xr_q;
	assign yq = {quo_q[N-2:0], ~trial[N]};

endmodule : ranc_gcdiv
`default_nettype wire

### sv/ranc_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ranc_back
// Pops classified items, normalizes a and b, forms cross products, compares,
// adds, normalizes the sum in the shared reduction unit; flagged items skip.
// ----------------------------------------------------------------------------
module ranc_back #(
	parameter int W = 16
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           q_valid,
	output logic                q_ready,
	input  wire logic [4*W+4:0] q_data,
	output logic                out_valid,
	input  wire logic           out_ready,
	output logic [ranc_pkg::SUM_NUM_W-1:0] sum_num,
	output logic [ranc_pkg::SUM_DEN_W-1:0] sum_den,
	output logic                is_equal,
	output logic                is_less,
	output logic                bad_den
);

	localparam int N = 2 * W + 2;

	ranc_pkg::ranc_state_t st_q, st_d;
	logic [4*W+4:0] it_q;
	logic [N-1:0]   gx, gy, rx, ry;
	logic           gstart, gdone;
	logic [W:0]     an_q, ad_q, bn_q, bd_q;
	logic           as_q, bs_q, sneg_q;
	logic [N-1:0]   sm_q, sd_q;
	logic           eq_q, lt_q;
	logic [2*W+1:0] t1, t2;
	logic           started_q;

	ranc_gcdiv #(.N(N)) u_gcd (
		.clk(clk), .arst_n(arst_n), .start(gstart), .x(gx), .y(gy),
		.done(gdone), .xq(rx), .yq(ry)
	);

	wire [W:0] f_an = it_q[0 +: W+1];
	wire [W:0] f_ad = it_q[W+1 +: W+1];
	wire [W:0] f_bn = it_q[2*(W+1) +: W+1];
	wire [W:0] f_bd = it_q[3*(W+1) +: W+1];
	wire       f_bad = it_q[4*W+4];

	always_comb begin
		st_d = st_q;
		case (st_q)
			ranc_pkg::ST_IDLE:   if (q_valid)
				st_d = q_data[4*W+4] ? ranc_pkg::ST_DONE : ranc_pkg::ST_NORM_A;
			ranc_pkg::ST_NORM_A: if (gdone) st_d = ranc_pkg::ST_NORM_B;
			ranc_pkg::ST_NORM_B: if (gdone) st_d = ranc_pkg::ST_CROSS;
			ranc_pkg::ST_CROSS:  st_d = ranc_pkg::ST_NORM_S;
			ranc_pkg::ST_NORM_S: if (gdone) st_d = ranc_pkg::ST_DONE;
			ranc_pkg::ST_DONE:   if (!out_valid || out_ready) st_d = ranc_pkg::ST_IDLE;
			default:             st_d = ranc_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		q_ready = (st_q == ranc_pkg::ST_IDLE);
		gstart  = !started_q && (st_q == ranc_pkg::ST_NORM_A || st_q == ranc_pkg::ST_NORM_B
			|| st_q == ranc_pkg::ST_NORM_S);
		case (st_q)
			ranc_pkg::ST_NORM_A: begin
				gx = N'(f_an[W-1:0]) | (N'(f_an[W] && f_an[W-1:0] == '0) << (W - 1));
				gy = N'(f_ad[W-1:0]) | (N'(f_ad[W] && f_ad[W-1:0] == '0) << (W - 1));
			end
			ranc_pkg::ST_NORM_B: begin
				gx = N'(f_bn[W-1:0]) | (N'(f_bn[W] && f_bn[W-1:0] == '0) << (W - 1));
				gy = N'(f_bd[W-1:0]) | (N'(f_bd[W] && f_bd[W-1:0] == '0) << (W - 1));
			end
			default: begin
				gx = sm_q;
				gy = sd_q;
			end
		endcase
		t1 = an_q * bd_q;
		t2 = bn_q * ad_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ranc_pkg::ST_IDLE;
			out_valid <= 1'b0;
			started_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (gdone || st_q == ranc_pkg::ST_IDLE) started_q <= 1'b0;
			else if (gstart) started_q <= 1'b1;
			if (st_q == ranc_pkg::ST_DONE && (!out_valid || out_ready)) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ranc_pkg::ST_IDLE && q_valid) it_q <= q_data;
		if (st_q == ranc_pkg::ST_NORM_A && gdone) begin
			an_q <= rx[W:0]; ad_q <= ry[W:0];
			as_q <= (rx != '0) && (f_an[W] != f_ad[W]);
		end
		if (st_q == ranc_pkg::ST_NORM_B && gdone) begin
			bn_q <= rx[W:0]; bd_q <= ry[W:0];
			bs_q <= (rx != '0) && (f_bn[W] != f_bd[W]);
		end
		if (st_q == ranc_pkg::ST_CROSS) begin
			eq_q <= (as_q == bs_q) && (t1 == t2);
			lt_q <= (as_q != bs_q) ? as_q : (as_q ? (t1 > t2) : (t1 < t2));
			sd_q <= N'(ad_q) * N'(bd_q);
			if (as_q == bs_q) begin
				sm_q <= N'(t1) + N'(t2); sneg_q <= as_q;
			end else if (t1 >= t2) begin
				sm_q <= N'(t1 - t2); sneg_q <= as_q;
			end else begin
				sm_q <= N'(t2 - t1); sneg_q <= bs_q;
			end
		end
		if (st_q == ranc_pkg::ST_DONE && (!out_valid || out_ready)) begin
			bad_den  <= f_bad;
			is_equal <= !f_bad && eq_q;
			is_less  <= !f_bad && lt_q;
			sum_num  <= f_bad ? '0 : (sneg_q && sm_q != '0) ?
				ranc_pkg::SUM_NUM_W'(-sm_q) : ranc_pkg::SUM_NUM_W'(sm_q);
			sum_den  <= f_bad ? '0 : ranc_pkg::SUM_DEN_W'(sd_q);
		end
		if (st_q == ranc_pkg::ST_NORM_S && gdone) begin
			sm_q <= rx; sd_q <= ry;
		end
	end

endmodule : ranc_back
`default_nettype wire

### sv/rational_add_normalize_compare_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rational_add_normalize_compare_core
// Adds two signed fractions in lowest terms and compares them.
// ----------------------------------------------------------------------------
// One item at a time in the back end: each item runs three reductions
// (a, b and the sum) through one shared binary-gcd and bit-serial divider.
// Each reduction runs a start step, the gcd steps, a load step and two
// bit-serial divisions; an item also passes pop, cross and output steps.
// An item with a zero denominator goes from the pop straight to the output.
// A two-entry queue lets the input side take items while the back end works.
module rational_add_normalize_compare_core #(
	parameter int OPERAND_WIDTH = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_tvalid,
	output logic      s_tready,
	// a_num, a_den, b_num, b_den
	input  wire logic [((4*OPERAND_WIDTH+7)/8)*8-1:0] s_tdata,
	output logic      m_tvalid,
	input  wire logic m_tready,
	// sum_num[32:0], sum_den[63:33], is_equal[64], is_less[65], bad_den[66], zero pad
	output logic [71:0] m_tdata
);

	localparam int W = OPERAND_WIDTH;

	logic           qv, qr;
	logic [4*W+4:0] qd;
	logic [ranc_pkg::SUM_NUM_W-1:0] sn;
	logic [ranc_pkg::SUM_DEN_W-1:0] sd;
	logic eq, lt, bd;

	ranc_front #(.W(W)) u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(s_tvalid), .in_ready(s_tready),
		.in_data(s_tdata[4*W-1:0]), .q_valid(qv), .q_ready(qr), .q_data(qd)
	);

	ranc_back #(.W(W)) u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(qv), .q_ready(qr), .q_data(qd),
		.out_valid(m_tvalid), .out_ready(m_tready), .sum_num(sn), .sum_den(sd),
		.is_equal(eq), .is_less(lt), .bad_den(bd)
	);

	assign m_tdata = {5'b0, bd, lt, eq, sd, sn};

	property p_bad_zero;
		@(posedge clk) disable iff (!arst_n) m_tvalid && m_tdata[66] |-> m_tdata[65:0] == '0;
	endproperty
	a_bad_zero: assert property (p_bad_zero) else $error("bad_den with nonzero result");

	property p_eq_lt;
		@(posedge clk) disable iff (!arst_n) m_tvalid |-> !(m_tdata[64] && m_tdata[65]);
	endproperty
	a_eq_lt: assert property (p_eq_lt) else $error("equal and less both set");

endmodule : rational_add_normalize_compare_core
`default_nettype wire
